// ----- src/assert_macros.svh -----
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/fscl_pkg.sv -----
package fscl_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int TICK_W     = 24;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PROG_HIGH_TICKS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROG_LOW_TICKS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_LOW_LIMIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_HIGH_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DONE_CLOCK_LIMIT = 3'd4;

  // Register defaults after reset.
  localparam logic [7:0]  PROG_HIGH_TICKS_RST  = 8'd10;
  localparam logic [7:0]  PROG_LOW_TICKS_RST   = 8'd5;
  localparam logic [15:0] INIT_LOW_LIMIT_RST   = 16'd200;
  localparam logic [23:0] INIT_HIGH_LIMIT_RST  = 24'hFFFFFF;
  localparam logic [7:0]  DONE_CLOCK_LIMIT_RST = 8'd50;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_PHIGH = 4'd1,
    PH_PLOWA = 4'd2,
    PH_WLOW  = 4'd3,
    PH_PLOWB = 4'd4,
    PH_WHIGH = 4'd5,
    PH_LOAD  = 4'd6,
    PH_SEND  = 4'd7,
    PH_DONE  = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_RUN    = 3'd1,
    ST_OK     = 3'd2,
    ST_TOLOW  = 3'd3,
    ST_TOHIGH = 3'd4,
    ST_TODONE = 3'd5
  } status_t;

  typedef struct packed {
    logic       start_req;
    logic       init_level;
    logic       done_level;
    logic       byte_valid;
    logic [7:0] byte_data;
    logic       byte_last;
  } in_t;

  typedef struct packed {
    logic       clk_out;
    logic       data_out;
    logic       prog_out;
    logic       byte_taken;
    logic       busy_res;
    logic [2:0] status;
  } out_t;

endpackage

// ----- src/fpga_serial_config_loader.sv -----
// Channel   Direction  Handshake            Beat content
// in_       input      in_valid/in_ready    one tick: start, init, done, offered byte
// out_      output     out_valid/out_ready  pin levels, byte_taken, busy, status
// cfg_      input      cfg_valid/cfg_ready  register index and write data
//
// Every input beat is one tick of the engine and yields exactly one result beat.
// A beat is accepted while the result register is empty or being taken; its result is
// visible in the next cycle, via the single state update pass into the result register.
// Reset (rst_n, synchronous, active low) restores the register defaults, an idle
// engine with clk 0, data 0, prog 1, and an empty result register.
// A stalled result holds, and the input accepts again as soon as it is taken.
module fpga_serial_config_loader (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  fscl_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output fscl_pkg::out_t                      out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fscl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fscl_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int TW = fscl_pkg::TICK_W;

  // Configuration registers.
  logic [7:0]  prog_high_ticks_r;
  logic [7:0]  prog_low_ticks_r;
  logic [15:0] init_low_limit_r;
  logic [23:0] init_high_limit_r;
  logic [7:0]  done_clock_limit_r;

  // Engine state and current pin levels.
  fscl_pkg::phase_t  phase_r, phase_nxt;
  logic [TW-1:0]     tick_r, tick_nxt;
  logic [7:0]        shift_r, shift_nxt;
  logic [2:0]        bit_idx_r, bit_idx_nxt;
  logic              half_r, half_nxt;
  logic              final_r, final_nxt;
  fscl_pkg::status_t code_r, code_nxt;
  logic              pin_clk_r, pin_clk_nxt;
  logic              pin_data_r, pin_data_nxt;
  logic              pin_prog_r, pin_prog_nxt;
  logic              taken;

  // Result register.
  logic           out_valid_r;
  fscl_pkg::out_t out_r;
  fscl_pkg::out_t out_nxt;

  logic          in_fire;
  logic [TW-1:0] tick_inc;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign tick_inc  = tick_r + TW'(1);

  // Configuration writes; an index past the register list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prog_high_ticks_r  <= fscl_pkg::PROG_HIGH_TICKS_RST;
      prog_low_ticks_r   <= fscl_pkg::PROG_LOW_TICKS_RST;
      init_low_limit_r   <= fscl_pkg::INIT_LOW_LIMIT_RST;
      init_high_limit_r  <= fscl_pkg::INIT_HIGH_LIMIT_RST;
      done_clock_limit_r <= fscl_pkg::DONE_CLOCK_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fscl_pkg::REG_PROG_HIGH_TICKS:  prog_high_ticks_r  <= cfg_data[7:0];
        fscl_pkg::REG_PROG_LOW_TICKS:   prog_low_ticks_r   <= cfg_data[7:0];
        fscl_pkg::REG_INIT_LOW_LIMIT:   init_low_limit_r   <= cfg_data[15:0];
        fscl_pkg::REG_INIT_HIGH_LIMIT:  init_high_limit_r  <= cfg_data[23:0];
        fscl_pkg::REG_DONE_CLOCK_LIMIT: done_clock_limit_r <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // One tick of the sequencer. Every register holds unless the phase drives it.
  always_comb begin
    phase_nxt    = phase_r;
    tick_nxt     = tick_r;
    shift_nxt    = shift_r;
    bit_idx_nxt  = bit_idx_r;
    half_nxt     = half_r;
    final_nxt    = final_r;
    code_nxt     = code_r;
    pin_clk_nxt  = pin_clk_r;
    pin_data_nxt = pin_data_r;
    pin_prog_nxt = pin_prog_r;
    taken        = 1'b0;

    unique case (phase_r)
      fscl_pkg::PH_PHIGH: begin
        // Prog stays high until the tick count reaches the programmed value, then drops.
        if (tick_r >= {16'd0, prog_high_ticks_r}) begin
          phase_nxt    = fscl_pkg::PH_PLOWA;
          tick_nxt     = '0;
          pin_prog_nxt = 1'b0;
        end else begin
          tick_nxt = tick_inc;
        end
      end
      fscl_pkg::PH_PLOWA: begin
        if (tick_r >= {16'd0, prog_low_ticks_r}) begin
          phase_nxt = fscl_pkg::PH_WLOW;
          tick_nxt  = '0;
        end else begin
          tick_nxt = tick_inc;
        end
      end
      fscl_pkg::PH_WLOW: begin
        // Wait for init to fall; running out of samples releases prog and fails.
        if (tick_r < {8'd0, init_low_limit_r} && !in_data.init_level) begin
          phase_nxt = fscl_pkg::PH_PLOWB;
          tick_nxt  = '0;
        end else if (tick_inc >= {8'd0, init_low_limit_r}) begin
          pin_prog_nxt = 1'b1;
          phase_nxt    = fscl_pkg::PH_IDLE;
          code_nxt     = fscl_pkg::ST_TOLOW;
          tick_nxt     = '0;
          half_nxt     = 1'b0;
        end else begin
          tick_nxt = tick_inc;
        end
      end
      fscl_pkg::PH_PLOWB: begin
        if (tick_r >= {16'd0, prog_low_ticks_r}) begin
          phase_nxt    = fscl_pkg::PH_WHIGH;
          tick_nxt     = '0;
          pin_prog_nxt = 1'b1;
        end else begin
          tick_nxt = tick_inc;
        end
      end
      fscl_pkg::PH_WHIGH: begin
        // The count wraps at its full width before the limit compare.
        if (tick_r < init_high_limit_r && in_data.init_level) begin
          phase_nxt = fscl_pkg::PH_LOAD;
          tick_nxt  = '0;
        end else if (tick_inc >= init_high_limit_r) begin
          phase_nxt = fscl_pkg::PH_IDLE;
          code_nxt  = fscl_pkg::ST_TOHIGH;
          tick_nxt  = '0;
          half_nxt  = 1'b0;
        end else begin
          tick_nxt = tick_inc;
        end
      end
      fscl_pkg::PH_LOAD: begin
        // Take the offered byte and present its first bit with the clock low.
        if (in_data.byte_valid) begin
          taken        = 1'b1;
          shift_nxt    = in_data.byte_data;
          final_nxt    = in_data.byte_last;
          bit_idx_nxt  = '0;
          pin_clk_nxt  = 1'b0;
          pin_data_nxt = in_data.byte_data[7];
          half_nxt     = 1'b1;
          phase_nxt    = fscl_pkg::PH_SEND;
        end
      end
      fscl_pkg::PH_SEND: begin
        if (half_r) begin
          pin_clk_nxt = 1'b1;
          shift_nxt   = {shift_r[6:0], 1'b0};
          half_nxt    = 1'b0;
          if (bit_idx_r == 3'd7) begin
            bit_idx_nxt = '0;
            if (final_r) begin
              phase_nxt = fscl_pkg::PH_DONE;
              tick_nxt  = '0;
            end else begin
              phase_nxt = fscl_pkg::PH_LOAD;
            end
          end else begin
            bit_idx_nxt = bit_idx_r + 3'd1;
          end
        end else begin
          pin_clk_nxt  = 1'b0;
          pin_data_nxt = shift_r[7];
          half_nxt     = 1'b1;
        end
      end
      fscl_pkg::PH_DONE: begin
        // Extra clocks until done rises or the clock budget is spent.
        if (half_r) begin
          pin_clk_nxt = 1'b1;
          tick_nxt    = tick_inc;
          half_nxt    = 1'b0;
        end else if (in_data.done_level || tick_r >= {16'd0, done_clock_limit_r}) begin
          pin_clk_nxt  = 1'b0;
          pin_data_nxt = 1'b1;
          phase_nxt    = fscl_pkg::PH_IDLE;
          code_nxt     = in_data.done_level ? fscl_pkg::ST_OK : fscl_pkg::ST_TODONE;
          tick_nxt     = '0;
          half_nxt     = 1'b0;
        end else begin
          pin_clk_nxt = 1'b0;
          half_nxt    = 1'b1;
        end
      end
      default: begin
        // Idle; any code outside the phase list behaves as idle too.
        phase_nxt = fscl_pkg::PH_IDLE;
        if (in_data.start_req) begin
          phase_nxt    = fscl_pkg::PH_PHIGH;
          tick_nxt     = '0;
          half_nxt     = 1'b0;
          bit_idx_nxt  = '0;
          code_nxt     = fscl_pkg::ST_RUN;
          pin_clk_nxt  = 1'b0;
          pin_prog_nxt = 1'b1;
        end
      end
    endcase

    out_nxt.clk_out    = pin_clk_nxt;
    out_nxt.data_out   = pin_data_nxt;
    out_nxt.prog_out   = pin_prog_nxt;
    out_nxt.byte_taken = taken;
    out_nxt.busy_res   = (phase_nxt != fscl_pkg::PH_IDLE);
    out_nxt.status     = code_nxt;
  end

  // State advances only on an accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= fscl_pkg::PH_IDLE;
      tick_r     <= '0;
      shift_r    <= '0;
      bit_idx_r  <= '0;
      half_r     <= 1'b0;
      final_r    <= 1'b0;
      code_r     <= fscl_pkg::ST_IDLE;
      pin_clk_r  <= 1'b0;
      pin_data_r <= 1'b0;
      pin_prog_r <= 1'b1;
    end else if (in_fire) begin
      phase_r    <= phase_nxt;
      tick_r     <= tick_nxt;
      shift_r    <= shift_nxt;
      bit_idx_r  <= bit_idx_nxt;
      half_r     <= half_nxt;
      final_r    <= final_nxt;
      code_r     <= code_nxt;
      pin_clk_r  <= pin_clk_nxt;
      pin_data_r <= pin_data_nxt;
      pin_prog_r <= pin_prog_nxt;
    end
  end

  // The result register accepts a new beat whenever its last one has been taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_r <= out_nxt;
    end
  end

endmodule

// ----- src/fscl_checker.sv -----
`include "assert_macros.svh"

module fscl_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input fscl_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_ready,
  input fscl_pkg::out_t out_data
);

  logic in_fire;
  logic out_stall;
  logic no_offer;

  assign in_fire   = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;
  assign no_offer  = in_fire && !in_data.byte_valid;

  `ASSERT_CLK(a_out_hold, out_stall |=> out_valid && $stable(out_data), "stalled result moved")
  `ASSERT_CLK(a_in_gives_out, in_fire |=> out_valid, "accepted beat gave no result")
  `ASSERT_CLK(a_stall_blocks_in, out_stall |-> !in_ready, "input taken while result stalled")
  `ASSERT_CLK(a_no_phantom_byte, no_offer |=> !out_data.byte_taken, "phantom byte taken")
  `ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind fpga_serial_config_loader fscl_checker u_fscl_checker (.*);
